// ===== hw/rtl/kdph_pkg.sv =====
`timescale 1ns / 1ps

package kdph_pkg;

  // Fixed field widths
  localparam int RAW_W      = 3;
  localparam int PRESS_W    = 7;
  localparam int REL_W      = 8;
  localparam int HOLD_W     = 16;
  localparam int INTEG_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Default key count
  localparam int KEYS_DEF = 3;

  // Register reset values
  localparam logic        [PRESS_W-1:0] PRESS_LIMIT_RST   = 7'd20;
  localparam logic signed [REL_W-1:0]   RELEASE_LIMIT_RST = -8'sd20;
  localparam logic        [HOLD_W-1:0]  HOLD_TICKS_RST    = 16'd2000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_LIMIT   = 2'd0,
    CFG_RELEASE_LIMIT = 2'd1,
    CFG_HOLD_TICKS    = 2'd2
  } cfg_idx_t;

  // Per-key result of one scan tick
  typedef struct packed {
    logic pressed;
    logic short_press;
    logic hold;
    logic active;
  } key_evt_t;

endpackage

// ===== hw/rtl/kdph_key.sv =====
`timescale 1ns / 1ps

module kdph_key
  import kdph_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      down,
  input  logic        [PRESS_W-1:0] press_limit,
  input  logic signed [REL_W-1:0]   release_limit,
  input  logic        [HOLD_W-1:0]  hold_ticks,
  output key_evt_t                  evt
);

  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic                      pressed_r, pressed_nxt;
  logic        [HOLD_W-1:0]  timer_r, timer_nxt;
  logic                      fired_r, fired_nxt;

  logic signed [INTEG_W:0]   sum;
  logic signed [INTEG_W:0]   press_ext;
  logic signed [INTEG_W:0]   rel_ext;
  logic        [HOLD_W-1:0]  timer_inc;

  assign press_ext = $signed({2'b00, press_limit});
  assign rel_ext   = $signed({release_limit[REL_W-1], release_limit});
  assign sum       = $signed({integ_r[INTEG_W-1], integ_r})
                   + (down ? 9'sd1 : -9'sd1);
  // Saturate rather than wrap
  assign timer_inc = (timer_r == {HOLD_W{1'b1}}) ? timer_r : timer_r + 1'b1;

  always_comb begin
    integ_nxt       = integ_r;
    pressed_nxt     = pressed_r;
    timer_nxt       = timer_r;
    fired_nxt       = fired_r;
    evt.short_press = 1'b0;
    evt.hold        = 1'b0;
    evt.active      = 1'b0;

    // Integrate and clamp; press test first so overlapping limits never bounce
    if (sum >= press_ext) begin
      integ_nxt   = $signed({1'b0, press_limit});
      pressed_nxt = 1'b1;
      evt.active  = 1'b1;
    end else if (sum <= rel_ext) begin
      integ_nxt   = release_limit;
      pressed_nxt = 1'b0;
    end else begin
      integ_nxt  = sum[INTEG_W-1:0];
      evt.active = 1'b1;
    end

    if (pressed_nxt && !pressed_r) begin
      timer_nxt = '0;
      fired_nxt = 1'b0;
    end else if (pressed_nxt) begin
      if (timer_inc >= hold_ticks) begin
        timer_nxt = '0;
        fired_nxt = 1'b1;
        evt.hold  = 1'b1;
      end else begin
        timer_nxt = timer_inc;
      end
    end else if (pressed_r) begin
      evt.short_press = !fired_r;
    end

    evt.pressed = pressed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r   <= '0;
      pressed_r <= 1'b0;
      timer_r   <= '0;
      fired_r   <= 1'b0;
    end else if (en) begin
      integ_r   <= integ_nxt;
      pressed_r <= pressed_nxt;
      timer_r   <= timer_nxt;
      fired_r   <= fired_nxt;
    end
  end

endmodule

// ===== hw/rtl/key_debounce_press_hold_top.sv =====
`timescale 1ns / 1ps

// Channel  Ports                                    Direction  Transfer when
// in       in_valid, in_stall, in_raw_levels        sink       in_valid && !in_stall
// out      out_valid, out_stall, out_*_mask,        source     out_valid && !out_stall
//          out_any_active
// cfg      cfg_wr_en, cfg_index, cfg_data           sink       cfg_wr_en
//
// One scan tick is taken every cycle unless in is stalled; its result goes
// through the input register, then the per-key update into the result
// register, from which it can transfer out.
// Throughput is bounded only by the result register being drained.
// Reset (rst_n low, synchronous) clears all key state and loads default limits.
// A stall on out holds the result register and back-pressures in only once
// both the input and result registers are full.

module key_debounce_press_hold_top
  import kdph_pkg::*;
#(
  parameter int KEYS = KEYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [RAW_W-1:0]      in_raw_levels,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RAW_W-1:0]      out_pressed_mask,
  output logic [RAW_W-1:0]      out_short_press_mask,
  output logic [RAW_W-1:0]      out_hold_mask,
  output logic                  out_any_active,

  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic        [PRESS_W-1:0] press_limit_r;
  logic signed [REL_W-1:0]   release_limit_r;
  logic        [HOLD_W-1:0]  hold_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_limit_r   <= PRESS_LIMIT_RST;
      release_limit_r <= RELEASE_LIMIT_RST;
      hold_ticks_r    <= HOLD_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PRESS_LIMIT:   press_limit_r   <= cfg_data[PRESS_W-1:0];
        CFG_RELEASE_LIMIT: release_limit_r <= $signed(cfg_data[REL_W-1:0]);
        CFG_HOLD_TICKS:    hold_ticks_r    <= cfg_data[HOLD_W-1:0];
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  // Input register
  logic             in_valid_r;
  logic [RAW_W-1:0] raw_r;
  logic             res_ready;
  logic             in_xfer;
  logic             tick;

  assign res_ready = !out_valid || !out_stall;
  assign in_stall  = in_valid_r && !res_ready;
  assign in_xfer   = in_valid && !in_stall;
  // Advance the held scan tick into the keys and the result register
  assign tick      = in_valid_r && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || res_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      raw_r <= in_raw_levels;
    end
  end

  // Per-key debouncers
  key_evt_t         evt   [KEYS];
  logic [KEYS-1:0]  act_vec;
  logic [RAW_W-1:0] pmask_nxt, smask_nxt, hmask_nxt;

  for (genvar k = 0; k < KEYS; k++) begin : g_key
    logic down;
    // Keys beyond the input field always see a low line, i.e. held down
    if (k < RAW_W) begin : g_wired
      assign down = !raw_r[k];
    end else begin : g_unwired
      assign down = 1'b1;
    end

    kdph_key u_key (
      .clk           (clk),
      .rst_n         (rst_n),
      .en            (tick),
      .down          (down),
      .press_limit   (press_limit_r),
      .release_limit (release_limit_r),
      .hold_ticks    (hold_ticks_r),
      .evt           (evt[k])
    );

    assign act_vec[k] = evt[k].active;
  end

  // Masks carry only the keys that fit the output field
  for (genvar j = 0; j < RAW_W; j++) begin : g_mask
    if (j < KEYS) begin : g_live
      assign pmask_nxt[j] = evt[j].pressed;
      assign smask_nxt[j] = evt[j].short_press;
      assign hmask_nxt[j] = evt[j].hold;
    end else begin : g_dead
      assign pmask_nxt[j] = 1'b0;
      assign smask_nxt[j] = 1'b0;
      assign hmask_nxt[j] = 1'b0;
    end
  end

  // Result register
  logic             out_valid_r;
  logic [RAW_W-1:0] pmask_r, smask_r, hmask_r;
  logic             active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      pmask_r  <= pmask_nxt;
      smask_r  <= smask_nxt;
      hmask_r  <= hmask_nxt;
      active_r <= |act_vec;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_pressed_mask     = pmask_r;
  assign out_short_press_mask = smask_r;
  assign out_hold_mask        = hmask_r;
  assign out_any_active       = active_r;

endmodule

// ===== hw/rtl/kdph_chk.sv =====
`timescale 1ns / 1ps

module kdph_chk
  import kdph_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input logic [RAW_W-1:0] out_pressed_mask,
  input logic [RAW_W-1:0] out_short_press_mask,
  input logic [RAW_W-1:0] out_hold_mask,
  input logic             out_any_active
);

  // A short press is a release, so its key cannot be shown pressed
  a_short_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_short_press_mask & out_pressed_mask) == '0)
    else $error("short press on a key still pressed");

  // A hold only fires on a pressed key
  a_hold_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hold_mask & ~out_pressed_mask) == '0)
    else $error("hold on a released key");

  // Any pressed key keeps the block active
  a_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pressed_mask != '0) |-> out_any_active)
    else $error("pressed key without activity flag");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pressed_mask)
      && $stable(out_short_press_mask) && $stable(out_hold_mask)
      && $stable(out_any_active)))
    else $error("stalled result changed");

endmodule

bind key_debounce_press_hold_top kdph_chk u_kdph_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_pressed_mask     (out_pressed_mask),
  .out_short_press_mask (out_short_press_mask),
  .out_hold_mask        (out_hold_mask),
  .out_any_active       (out_any_active)
);
